[hw/rtl/tmrcc_pkg.sv]
`timescale 1ns / 1ps

package tmrcc_pkg;

  // Stream payload widths in bits, padded to whole bytes.
  localparam int InDataW  = 8;
  localparam int OutDataW = 40;

  // Bit positions of the input fields.
  localparam int InTickBit = 0;
  localparam int InPinBit  = 1;

  // Bit positions of the result fields.
  localparam int OutCountLsb    = 0;
  localparam int OutOvfBit      = 16;
  localparam int OutIrqBit      = 17;
  localparam int OutPinBit      = 18;
  localparam int OutCapBit      = 19;
  localparam int OutCapturedLsb = 20;
  localparam int OutDownBit     = 36;

  // Configuration register indexes.
  localparam logic [2:0] REG_TIMER_MODE     = 3'd0;
  localparam logic [2:0] REG_PERIOD_VALUE   = 3'd1;
  localparam logic [2:0] REG_COMPARE_VALUE  = 3'd2;
  localparam logic [2:0] REG_COMPARE_ACTION = 3'd3;
  localparam logic [2:0] REG_COMPARE_ENABLE = 3'd4;
  localparam logic [2:0] REG_CAPTURE_EDGE   = 3'd5;
  localparam logic [2:0] REG_IS_CHANNEL_0   = 3'd6;
  localparam logic [2:0] REG_OVF_IRQ_ENABLE = 3'd7;

  // Timer modes.
  localparam logic [2:0] MODE_STOP   = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_MODULO = 3'd2;
  localparam logic [2:0] MODE_UPDOWN = 3'd3;
  localparam logic [2:0] MODE_DOWN   = 3'd4;

  // Compare actions.
  localparam logic [2:0] ACT_SET          = 3'd0;
  localparam logic [2:0] ACT_CLEAR        = 3'd1;
  localparam logic [2:0] ACT_TOGGLE       = 3'd2;
  localparam logic [2:0] ACT_SET_UP       = 3'd3;
  localparam logic [2:0] ACT_CLEAR_UP     = 3'd4;
  localparam logic [2:0] ACT_CLEAR_PERIOD = 3'd5;
  localparam logic [2:0] ACT_SET_PERIOD   = 3'd6;
  localparam logic [2:0] ACT_FORCE_LOW    = 3'd7;

  // Capture edge select bits.
  localparam int EdgeRiseBit = 0;
  localparam int EdgeFallBit = 1;

endpackage

[hw/rtl/timer_counter_with_compare_capture.sv]
`timescale 1ns / 1ps

// Timer with one output-compare / input-capture channel.
// Results are registered. Throughput: one item per cycle while m_tready
// allows; a two-entry output stage (register plus skid) keeps the input
// open for one more item while a result waits.
// Reset (rst, synchronous): counter, direction, output pin, pin history,
// capture latch, all configuration registers and the output stage clear.
module timer_counter_with_compare_capture #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: [0] tick_enable, [1] pin_level, [7:2] zero.
  input  logic [tmrcc_pkg::InDataW-1:0] s_tdata,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: [15:0] count_value, [16] overflow_flag, [17] overflow_irq,
  // [18] out_pin, [19] capture_event, [35:20] captured_value,
  // [36] counting_down, [39:37] zero.
  output logic [tmrcc_pkg::OutDataW-1:0] m_tdata
);

  localparam int CW = COUNT_WIDTH;

  // Configuration registers.
  logic [2:0]  timer_mode;
  logic [15:0] period_value;
  logic [15:0] compare_value;
  logic [2:0]  compare_action;
  logic        compare_enable;
  logic [1:0]  capture_edge;
  logic        is_channel_zero;
  logic        overflow_irq_enable;

  // Timer state.
  logic [CW-1:0] counter;
  logic          direction_down;
  logic          output_level;
  logic          previous_pin;
  logic [CW-1:0] capture_latch;

  logic [CW-1:0] counter_next;
  logic          direction_down_next;
  logic          output_level_next;
  logic [CW-1:0] capture_latch_next;
  logic          ovf;
  logic          cap;

  // Output stage.
  logic                          out_valid;
  logic [tmrcc_pkg::OutDataW-1:0] out_data;
  logic                          skid_valid;
  logic [tmrcc_pkg::OutDataW-1:0] skid_data;
  logic [tmrcc_pkg::OutDataW-1:0] result;

  logic          push;
  logic          pop;
  logic          tick;
  logic          pin;
  logic [CW-1:0] top;
  logic [CW-1:0] thr;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign push      = s_tvalid && s_tready;
  assign pop       = out_valid && m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign tick    = s_tdata[tmrcc_pkg::InTickBit];
  assign pin     = s_tdata[tmrcc_pkg::InPinBit];
  assign top     = CW'(period_value);
  assign thr     = CW'(compare_value);
  assign cnt_inc = counter + 1'b1;
  assign cnt_dec = counter - 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode          <= tmrcc_pkg::MODE_STOP;
      period_value        <= '0;
      compare_value       <= '0;
      compare_action      <= tmrcc_pkg::ACT_SET;
      compare_enable      <= 1'b0;
      capture_edge        <= '0;
      is_channel_zero     <= 1'b0;
      overflow_irq_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmrcc_pkg::REG_TIMER_MODE:     timer_mode          <= cfg_data[2:0];
        tmrcc_pkg::REG_PERIOD_VALUE:   period_value        <= cfg_data;
        tmrcc_pkg::REG_COMPARE_VALUE:  compare_value       <= cfg_data;
        tmrcc_pkg::REG_COMPARE_ACTION: compare_action      <= cfg_data[2:0];
        tmrcc_pkg::REG_COMPARE_ENABLE: compare_enable      <= cfg_data[0];
        tmrcc_pkg::REG_CAPTURE_EDGE:   capture_edge        <= cfg_data[1:0];
        tmrcc_pkg::REG_IS_CHANNEL_0:   is_channel_zero     <= cfg_data[0];
        tmrcc_pkg::REG_OVF_IRQ_ENABLE: overflow_irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Counter advance by mode; only a tick moves the counter.
  always_comb begin
    counter_next        = counter;
    direction_down_next = direction_down;
    ovf                 = 1'b0;
    if (tick) begin
      unique case (timer_mode)
        tmrcc_pkg::MODE_FREE: begin
          counter_next = cnt_inc;
          ovf          = (cnt_inc == '0);
        end
        tmrcc_pkg::MODE_MODULO: begin
          if (counter == top) begin
            counter_next = '0;
            ovf          = 1'b1;
          end else begin
            counter_next = cnt_inc;
            ovf          = (cnt_inc == '0);
          end
        end
        tmrcc_pkg::MODE_UPDOWN: begin
          if (!direction_down) begin
            counter_next = cnt_inc;
            ovf          = (cnt_inc == '0);
            if (cnt_inc == top) direction_down_next = 1'b1;
          end else begin
            counter_next = cnt_dec;
            if (cnt_dec == '0) begin
              ovf                 = 1'b1;
              direction_down_next = 1'b0;
            end
          end
        end
        tmrcc_pkg::MODE_DOWN: begin
          counter_next = (counter == '0) ? top : cnt_dec;
          ovf          = (counter == '0) ? (top == '0) : (cnt_dec == '0);
        end
        default: ;
      endcase
    end
  end

  // Compare action on the updated count; later checks take priority.
  always_comb begin
    logic hi;
    logic atcmp;
    hi                = (compare_action == tmrcc_pkg::ACT_SET_UP);
    atcmp             = (compare_action == tmrcc_pkg::ACT_CLEAR_PERIOD);
    output_level_next = output_level;
    if (tick && compare_enable) begin
      unique case (compare_action)
        tmrcc_pkg::ACT_SET: begin
          if (counter_next == thr) output_level_next = 1'b1;
        end
        tmrcc_pkg::ACT_CLEAR: begin
          if (counter_next == thr) output_level_next = 1'b0;
        end
        tmrcc_pkg::ACT_TOGGLE: begin
          if (counter_next == thr) output_level_next = !output_level;
        end
        tmrcc_pkg::ACT_SET_UP, tmrcc_pkg::ACT_CLEAR_UP: begin
          if (timer_mode == tmrcc_pkg::MODE_UPDOWN) begin
            if (counter_next == thr) begin
              output_level_next = direction_down_next ? !hi : hi;
            end else if (counter_next > thr) begin
              output_level_next = hi;
            end else begin
              output_level_next = !hi;
            end
          end else begin
            if (counter_next == thr) output_level_next = hi;
            if (counter_next == '0)  output_level_next = !hi;
          end
        end
        tmrcc_pkg::ACT_CLEAR_PERIOD, tmrcc_pkg::ACT_SET_PERIOD: begin
          if (!is_channel_zero) begin
            if (timer_mode == tmrcc_pkg::MODE_MODULO) begin
              if (counter_next == thr) output_level_next = atcmp;
              if (counter_next == '0)  output_level_next = !atcmp;
            end else begin
              if (counter_next == top) output_level_next = !atcmp;
              if (counter_next == thr) output_level_next = atcmp;
            end
          end
        end
        tmrcc_pkg::ACT_FORCE_LOW: output_level_next = 1'b0;
        default: ;
      endcase
    end
  end

  // Input capture on the selected pin edge, in capture mode only.
  always_comb begin
    logic sel;
    sel = pin ? capture_edge[tmrcc_pkg::EdgeRiseBit]
              : capture_edge[tmrcc_pkg::EdgeFallBit];
    cap                = (pin != previous_pin) && sel && !compare_enable;
    capture_latch_next = cap ? counter_next : capture_latch;
  end

  // Result word.
  always_comb begin
    result = '0;
    result[tmrcc_pkg::OutCountLsb +: 16]    = 16'(counter_next);
    result[tmrcc_pkg::OutOvfBit]            = ovf;
    result[tmrcc_pkg::OutIrqBit]            = ovf && overflow_irq_enable;
    result[tmrcc_pkg::OutPinBit]            = output_level_next;
    result[tmrcc_pkg::OutCapBit]            = cap;
    result[tmrcc_pkg::OutCapturedLsb +: 16] = 16'(capture_latch_next);
    result[tmrcc_pkg::OutDownBit]           = direction_down_next;
  end

  // Timer state update on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter        <= '0;
      direction_down <= 1'b0;
      output_level   <= 1'b0;
      previous_pin   <= 1'b0;
      capture_latch  <= '0;
    end else if (push) begin
      counter        <= counter_next;
      direction_down <= direction_down_next;
      output_level   <= output_level_next;
      previous_pin   <= pin;
      capture_latch  <= capture_latch_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (push) begin
      skid_data <= result;
    end
  end

  // The skid entry is only filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while output register is empty");

  // A held skid entry is not dropped while the consumer stalls.
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> skid_valid)
    else $error("skid entry lost during stall");

  // Without a tick the counter does not move.
  a_no_tick_hold: assert property (@(posedge clk) disable iff (rst)
    (push && !tick) |=> (counter == $past(counter)))
    else $error("counter moved without a tick");

  // Compare mode never latches a capture.
  a_no_capture_in_compare: assert property (@(posedge clk) disable iff (rst)
    (push && compare_enable) |=> (capture_latch == $past(capture_latch)))
    else $error("capture latched in compare mode");

  // Direction only changes in up/down mode.
  a_dir_updown_only: assert property (@(posedge clk) disable iff (rst)
    (push && (timer_mode != tmrcc_pkg::MODE_UPDOWN))
      |=> (direction_down == $past(direction_down)))
    else $error("direction changed outside up/down mode");

endmodule
